// ----- src/pdr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_pkg: shared types and codes of the difficulty retarget block
// Holds the per-beat control word that travels with the data path and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package pdr_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMESPAN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_RETARGET = 2'd2;

    localparam int COMPACT_W  = 32;
    localparam int TIMESPAN_W = 30;

    // control word carried alongside each beat
    typedef struct packed {
        logic                 valid;
        logic                 bypass;
        logic                 halve;
        logic                 zero_ts;
        logic [COMPACT_W-1:0] pass_bits;
    } ctl_t;

endpackage
`default_nettype wire

// ----- src/pdr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_front: decode, time clamp and target multiply
// Stage A decodes the compact target, clamps the elapsed time and halves a
// large target; stage B forms 32x32 partial products; stage C sums them.
// ----------------------------------------------------------------------------
module pdr_front #(
    parameter int TARGET_BITS = 256
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     adv,
    input  wire                                     in_valid,
    input  wire  [pdr_pkg::COMPACT_W-1:0]           last_target_bits,
    input  wire  [31:0]                             last_time,
    input  wire  [31:0]                             first_time,
    input  wire  [pdr_pkg::TIMESPAN_W-1:0]          timespan,
    input  wire  [pdr_pkg::COMPACT_W-1:0]           limit_bits,
    input  wire                                     no_retarget,
    output logic [TARGET_BITS-1:0]                  lim_val,
    output pdr_pkg::ctl_t                           ctl_o,
    output logic [TARGET_BITS-1:0]                  prod_o
);

    localparam int NW = (TARGET_BITS + 31) / 32;
    localparam int LW = $clog2(TARGET_BITS + 1);

    function automatic logic [4:0] nb23(input logic [22:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int k = 0; k < 23; k++)
        begin
            if (v[k])
                n = 5'(k + 1);
        end
        return n;
    endfunction

    function automatic logic [TARGET_BITS-1:0] decode(input logic [31:0] c);
        logic [7:0]  sz;
        logic [22:0] m;
        logic [10:0] sh;
        logic [TARGET_BITS-1:0] v;
        sz = c[31:24];
        m  = c[22:0];
        sh = {sz - 8'd3, 3'b000};
        if (sz <= 8'd3)
            v = TARGET_BITS'(m >> {2'(8'd3 - sz), 3'b000});
        else if (sh >= 11'(TARGET_BITS))
            v = '0;
        else
            v = TARGET_BITS'(m) << sh;
        return v;
    endfunction

    function automatic logic [LW-1:0] bitlen(input logic [31:0] c);
        logic [7:0]  sz;
        logic [22:0] m;
        logic [22:0] mm;
        logic [10:0] sh;
        logic [10:0] rb;
        logic [LW-1:0] n;
        sz = c[31:24];
        m  = c[22:0];
        sh = {sz - 8'd3, 3'b000};
        rb = 11'(TARGET_BITS) - sh;
        mm = m;
        n  = '0;
        if (sz <= 8'd3)
            n = LW'(nb23(m >> {2'(8'd3 - sz), 3'b000}));
        else if (sh < 11'(TARGET_BITS))
        begin
            if (rb < 11'd23)
                mm = m & ((23'd1 << rb) - 23'd1);
            if (mm != 23'd0)
                n = LW'(nb23(mm)) + LW'(sh);
        end
        return n;
    endfunction

    logic [TARGET_BITS-1:0] val_dec;
    logic [LW-1:0]          lim_len;
    logic [LW-1:0]          val_len;
    logic                   halve;
    logic signed [32:0]     diff;
    logic [31:0]            ts_lo;
    logic [31:0]            ts_hi;
    logic [31:0]            e_next;

    assign lim_val = decode(limit_bits);
    assign val_dec = decode(last_target_bits);
    assign lim_len = bitlen(limit_bits);
    assign val_len = bitlen(last_target_bits);
    assign halve   = (lim_len != '0) && (val_len >= lim_len);

    always_comb
    begin
        diff  = $signed({1'b0, last_time}) - $signed({1'b0, first_time});
        ts_lo = {4'd0, timespan[29:2]};
        ts_hi = {timespan, 2'b00};
        if (diff < $signed({1'b0, ts_lo}))
            e_next = ts_lo;
        else if (diff > $signed({1'b0, ts_hi}))
            e_next = ts_hi;
        else
            e_next = diff[31:0];
    end

    // stage A
    pdr_pkg::ctl_t          a_ctl_reg;
    logic [TARGET_BITS-1:0] a_val_reg;
    logic [31:0]            a_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_ctl_reg <= '0;
        else if (adv)
        begin
            a_ctl_reg.valid     <= in_valid;
            a_ctl_reg.bypass    <= no_retarget;
            a_ctl_reg.halve     <= halve;
            a_ctl_reg.zero_ts   <= (timespan == '0);
            a_ctl_reg.pass_bits <= last_target_bits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_val_reg <= halve ? (val_dec >> 1) : val_dec;
            a_e_reg   <= e_next;
        end
    end

    // stage B: partial products, one lane per 32-bit limb
    pdr_pkg::ctl_t       b_ctl_reg;
    logic [63:0]         b_pp_reg [NW];
    logic [NW*32-1:0]    vpad;

    assign vpad = (NW*32)'(a_val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_ctl_reg <= '0;
        else if (adv)
            b_ctl_reg <= a_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NW; k++)
                b_pp_reg[k] <= 64'(vpad[32*k +: 32]) * 64'(a_e_reg);
        end
    end

    // stage C: low halves and high halves never overlap among themselves
    logic [NW*32-1:0] lo_w;
    logic [NW*32-1:0] hi_w;

    always_comb
    begin
        lo_w = '0;
        hi_w = '0;
        for (int k = 0; k < NW; k++)
            lo_w[32*k +: 32] = b_pp_reg[k][31:0];
        for (int k = 0; k < NW - 1; k++)
            hi_w[32*(k+1) +: 32] = b_pp_reg[k][63:32];
    end

    pdr_pkg::ctl_t          c_ctl_reg;
    logic [TARGET_BITS-1:0] c_prod_reg;
    logic [NW*32-1:0]       sum_w;

    assign sum_w = lo_w + hi_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_ctl_reg <= '0;
        else if (adv)
            c_ctl_reg <= b_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            c_prod_reg <= sum_w[TARGET_BITS-1:0];
    end

    assign ctl_o  = c_ctl_reg;
    assign prod_o = c_prod_reg;

endmodule
`default_nettype wire

// ----- src/pdr_div_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_div_cell: one restoring division step
// Shifts the top dividend bit into the remainder, subtracts the divisor when
// it fits and shifts the quotient bit into the bottom of the dividend word.
// ----------------------------------------------------------------------------
module pdr_div_cell #(
    parameter int TARGET_BITS = 256
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                adv,
    input  wire  [pdr_pkg::TIMESPAN_W-1:0]     divisor,
    input  pdr_pkg::ctl_t                      ctl_i,
    input  wire  [TARGET_BITS-1:0]             num_i,
    input  wire  [pdr_pkg::TIMESPAN_W-1:0]     rem_i,
    output pdr_pkg::ctl_t                      ctl_o,
    output logic [TARGET_BITS-1:0]             num_o,
    output logic [pdr_pkg::TIMESPAN_W-1:0]     rem_o
);

    localparam int RW = pdr_pkg::TIMESPAN_W + 1;

    logic [RW-1:0] trial;
    logic          fits;
    logic [RW-1:0] rem_next;

    pdr_pkg::ctl_t                   ctl_reg;
    logic [TARGET_BITS-1:0]          num_reg;
    logic [pdr_pkg::TIMESPAN_W-1:0]  rem_reg;

    always_comb
    begin
        trial    = {rem_i, num_i[TARGET_BITS-1]};
        fits     = trial >= {1'b0, divisor};
        rem_next = fits ? (trial - {1'b0, divisor}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (adv)
            ctl_reg <= ctl_i;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg <= {num_i[TARGET_BITS-2:0], fits};
            rem_reg <= rem_next[pdr_pkg::TIMESPAN_W-1:0];
        end
    end

    assign ctl_o = ctl_reg;
    assign num_o = num_reg;
    assign rem_o = rem_reg;

endmodule
`default_nettype wire

// ----- src/pdr_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pdr_back: limit clamp and compact encoding
// Undoes the halving, caps at the limit, finds the top nonzero byte and packs
// the normalized compact form into the output register; bypass keeps bits.
// ----------------------------------------------------------------------------
module pdr_back #(
    parameter int TARGET_BITS = 256
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               adv,
    input  pdr_pkg::ctl_t                     ctl_i,
    input  wire  [TARGET_BITS-1:0]            quot_i,
    input  wire  [TARGET_BITS-1:0]            lim_i,
    output logic                              valid_o,
    output logic [pdr_pkg::COMPACT_W-1:0]     bits_o
);

    localparam int NBY = (TARGET_BITS + 7) / 8;
    localparam int SW  = $clog2(NBY + 2);

    // P1: clamp
    logic [TARGET_BITS-1:0] q;
    pdr_pkg::ctl_t          p1_ctl_reg;
    logic [TARGET_BITS-1:0] p1_val_reg;

    always_comb
    begin
        q = ctl_i.halve ? (quot_i << 1) : quot_i;
        if (ctl_i.zero_ts || (q > lim_i))
            q = lim_i;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_ctl_reg <= '0;
        else if (adv)
            p1_ctl_reg <= ctl_i;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            p1_val_reg <= q;
    end

    // P2: significant byte count
    logic [NBY*8-1:0] vpad;
    logic [SW-1:0]    sz;
    pdr_pkg::ctl_t    p2_ctl_reg;
    logic [NBY*8-1:0] p2_val_reg;
    logic [SW-1:0]    p2_sz_reg;

    assign vpad = (NBY*8)'(p1_val_reg);

    always_comb
    begin
        sz = '0;
        for (int k = 0; k < NBY; k++)
        begin
            if (vpad[8*k +: 8] != 8'd0)
                sz = SW'(k + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_ctl_reg <= '0;
        else if (adv)
            p2_ctl_reg <= p1_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_val_reg <= vpad;
            p2_sz_reg  <= sz;
        end
    end

    // P3: pick the three top bytes, zeros below the value
    logic [NBY*8+23:0] ext;
    logic [23:0]       mant;
    logic [7:0]        size;
    logic [31:0]       enc;
    logic              out_valid_reg;
    logic [31:0]       out_bits_reg;

    always_comb
    begin
        ext  = {p2_val_reg, 24'd0};
        mant = ext[{p2_sz_reg, 3'b000} +: 24];
        size = 8'(p2_sz_reg);
        if (mant[23])
        begin
            mant = mant >> 8;
            size = size + 8'd1;
        end
        enc = {size, mant};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= p2_ctl_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_bits_reg <= p2_ctl_reg.bypass ? p2_ctl_reg.pass_bits : enc;
    end

    assign valid_o = out_valid_reg;
    assign bits_o  = out_bits_reg;

endmodule
`default_nettype wire

// ----- src/pow_difficulty_retarget_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pow_difficulty_retarget_top: compact target retarget pipeline
// Computes the next compact target from the last target and window times.
// ----------------------------------------------------------------------------
// One beat is accepted every cycle while the output side takes results.
// A beat passes three front stages (decode/clamp, partial products, sum), a
// row of TARGET_BITS division cells, one quotient bit per cell, and three
// back stages (limit clamp, byte count, encode into the output register).
// The whole pipeline advances together and holds while a result waits.
// Write configuration only while no beat is in flight.
module pow_difficulty_retarget_top #(
    parameter int TARGET_BITS = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [95:0] s_tdata,   // last_target_bits, last_time, first_time
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // next_target_bits
    input  wire         cfg_wen,
    input  wire  [1:0]  cfg_addr,
    input  wire  [31:0] cfg_wdata
);

    logic [pdr_pkg::TIMESPAN_W-1:0] timespan_reg;
    logic [pdr_pkg::COMPACT_W-1:0]  limit_reg;
    logic                           no_retarget_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timespan_reg    <= 30'd302400;
            limit_reg       <= 32'h1E0F_FFFF;
            no_retarget_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                pdr_pkg::CFG_TIMESPAN:    timespan_reg    <= cfg_wdata[29:0];
                pdr_pkg::CFG_LIMIT:       limit_reg       <= cfg_wdata;
                pdr_pkg::CFG_NO_RETARGET: no_retarget_reg <= cfg_wdata[0];
                default:                  ;
            endcase
        end
    end

    logic adv;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic [TARGET_BITS-1:0] lim_val;

    pdr_pkg::ctl_t                  ctl_c [TARGET_BITS+1];
    logic [TARGET_BITS-1:0]         num_c [TARGET_BITS+1];
    logic [pdr_pkg::TIMESPAN_W-1:0] rem_c [TARGET_BITS+1];

    pdr_front #(
        .TARGET_BITS (TARGET_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .in_valid         (s_tvalid),
        .last_target_bits (s_tdata[31:0]),
        .last_time        (s_tdata[63:32]),
        .first_time       (s_tdata[95:64]),
        .timespan         (timespan_reg),
        .limit_bits       (limit_reg),
        .no_retarget      (no_retarget_reg),
        .lim_val          (lim_val),
        .ctl_o            (ctl_c[0]),
        .prod_o           (num_c[0])
    );

    assign rem_c[0] = '0;

    for (genvar i = 0; i < TARGET_BITS; i++)
    begin : g_cell
        pdr_div_cell #(
            .TARGET_BITS (TARGET_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .divisor (timespan_reg),
            .ctl_i   (ctl_c[i]),
            .num_i   (num_c[i]),
            .rem_i   (rem_c[i]),
            .ctl_o   (ctl_c[i+1]),
            .num_o   (num_c[i+1]),
            .rem_o   (rem_c[i+1])
        );
    end

    pdr_back #(
        .TARGET_BITS (TARGET_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_i   (ctl_c[TARGET_BITS]),
        .quot_i  (num_c[TARGET_BITS]),
        .lim_i   (lim_val),
        .valid_o (m_tvalid),
        .bits_o  (m_tdata)
    );

    // a retargeted result never carries the sign bit
    a_sign_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !no_retarget_reg |-> !m_tdata[23])
        else $error("retarget result has sign bit set");

    // a multi-byte retargeted result is normalized
    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !no_retarget_reg && (m_tdata[31:24] > 8'd3)
            |-> (m_tdata[23:15] != 9'd0))
        else $error("retarget result mantissa not normalized");

    // a stalled output freezes the whole pipeline, including the input side
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

endmodule
`default_nettype wire
